// ----- rtl/heap_sorter_assert.svh -----
// Assertion macros for the heap sorter.
// Used by the top level; no other dependencies.
`ifndef HEAP_SORTER_ASSERT_SVH
`define HEAP_SORTER_ASSERT_SVH
`ifndef SYNTHESIS
`define HS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap_sorter: same-cycle check failed");
`define HS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap_sorter: next-cycle check failed");
`else
`define HS_ASSERT_IMP(label, clk, rst, ante, cons)
`define HS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/hsort_pkg.sv -----
// Shared constants and types of the heap sorter.
// No dependencies; imported by the top level.
`default_nettype none
package hsort_pkg;
   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
   localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);
   localparam int CHILD_BITS = ADDR_BITS + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_FETCH,
      ST_READ,
      ST_CMP,
      ST_OUT
   } state_type;

   typedef enum logic {
      PH_BUILD,
      PH_SORT
   } phase_type;
endpackage
`default_nettype wire

// ----- rtl/hsort_ram.sv -----
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`default_nettype none
module hsort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic      [WIDTH-1:0]         rd_a_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic      [WIDTH-1:0]         rd_b_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;
endmodule
`default_nettype wire

// ----- rtl/heap_sorter.sv -----
// Heap sorter top level: collects a set of values, heapsorts them in RAM and emits them.
// Depends on hsort_pkg, hsort_ram and heap_sorter_assert.svh.
//
//   Channel   Ports                                           Transaction when
//   request   start, busy, req_value, req_last_item           start high, busy low
//   response  rsp_strobe, rsp_sorted_value, rsp_last_result,  rsp_strobe high
//             rsp_dropped
//
// Items are loaded one per cycle. Each sift-down first fetches the value to be sifted,
// then for each heap level reads both children, then compares and writes back; once
// the set is sorted, it is emitted in ascending order. Reset is synchronous and clears
// count, flag and state. Results cannot be stalled; busy is high from the cycle after
// the last item until the cycle that carries the last result, in which a new item may
// already be taken.
`default_nettype none
`include "heap_sorter_assert.svh"
module heap_sorter import hsort_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   input  wire logic                         req_last_item,
   output logic                              rsp_strobe,
   output logic signed [VALUE_BITS-1:0]      rsp_sorted_value,
   output logic                              rsp_last_result,
   output logic                              rsp_dropped
);
   state_type                     state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic                          overflow_ff, overflow_in;
   logic [COUNT_BITS-1:0]         k_ff, k_in;
   logic [COUNT_BITS-1:0]         len_ff, len_in;
   logic [ADDR_BITS-1:0]          node_ff, node_in;
   logic signed [VALUE_BITS-1:0]  hold_ff, hold_in;
   logic                          left_ok_ff, left_ok_in;
   logic                          right_ok_ff, right_ok_in;
   logic [ADDR_BITS-1:0]          out_idx_ff, out_idx_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_dropped_ff, rsp_dropped_in;

   logic                          wr_en;
   logic [ADDR_BITS-1:0]          wr_addr;
   logic [VALUE_BITS-1:0]         wr_data;
   logic [ADDR_BITS-1:0]          rd_a_addr;
   logic [ADDR_BITS-1:0]          rd_b_addr;
   logic [VALUE_BITS-1:0]         rd_a_data;
   logic [VALUE_BITS-1:0]         rd_b_data;

   logic                          accept;
   logic                          has_room;
   logic [COUNT_BITS-1:0]         k_less;
   logic [CHILD_BITS-1:0]         left_idx;
   logic [CHILD_BITS-1:0]         right_idx;
   logic signed [VALUE_BITS-1:0]  left_val;
   logic signed [VALUE_BITS-1:0]  right_val;
   logic                          take_right;
   logic signed [VALUE_BITS-1:0]  big_val;
   logic [CHILD_BITS-1:0]         big_idx;
   logic                          promote;
   logic                          out_last;

   hsort_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   assign accept     = start && (state_ff == ST_IDLE);
   assign has_room   = count_ff < COUNT_BITS'(MAX_ITEMS);
   assign k_less     = k_ff - COUNT_BITS'(1);
   assign left_idx   = CHILD_BITS'({node_ff, 1'b1});
   assign right_idx  = left_idx + CHILD_BITS'(1);
   assign left_val   = $signed(rd_a_data);
   assign right_val  = $signed(rd_b_data);
   assign take_right = right_ok_ff && (right_val > left_val);
   assign big_val    = take_right ? right_val : left_val;
   assign big_idx    = take_right ? right_idx : left_idx;
   assign promote    = left_ok_ff && (big_val > hold_ff);
   assign out_last   = COUNT_BITS'(out_idx_ff) == (count_ff - COUNT_BITS'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_item) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = (count_ff > COUNT_BITS'(1)) ? ST_LOAD : ST_OUT;
         end
         ST_LOAD:  state_in = ST_FETCH;
         ST_FETCH: state_in = ST_READ;
         ST_READ:  state_in = ST_CMP;
         ST_CMP: begin
            if (promote) begin
               state_in = ST_READ;
            end else if (phase_ff == PH_BUILD || k_ff > COUNT_BITS'(2)) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      k_in           = k_ff;
      len_in         = len_ff;
      node_in        = node_ff;
      hold_in        = hold_ff;
      left_ok_in     = left_ok_ff;
      right_ok_in    = right_ok_ff;
      out_idx_in     = '0;
      rsp_strobe_in  = 1'b0;
      rsp_last_in    = rsp_last_ff;
      rsp_dropped_in = rsp_dropped_ff;
      wr_en          = 1'b0;
      wr_addr        = ADDR_BITS'(count_ff);
      wr_data        = req_value;
      rd_a_addr      = '0;
      rd_b_addr      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + COUNT_BITS'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            phase_in = PH_BUILD;
            k_in     = count_ff >> 1;
         end
         ST_LOAD: begin
            rd_a_addr = (phase_ff == PH_SORT) ? '0 : ADDR_BITS'(k_less);
            rd_b_addr = ADDR_BITS'(k_less);
         end
         ST_FETCH: begin
            if (phase_ff == PH_SORT) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_BITS'(k_less);
               wr_data = rd_a_data;
               hold_in = right_val;
               node_in = '0;
               len_in  = k_less;
            end else begin
               hold_in = left_val;
               node_in = ADDR_BITS'(k_less);
               len_in  = count_ff;
            end
         end
         ST_READ: begin
            rd_a_addr   = ADDR_BITS'(left_idx);
            rd_b_addr   = ADDR_BITS'(right_idx);
            left_ok_in  = left_idx < CHILD_BITS'(len_ff);
            right_ok_in = right_idx < CHILD_BITS'(len_ff);
         end
         ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = node_ff;
            if (promote) begin
               wr_data = big_val;
               node_in = ADDR_BITS'(big_idx);
            end else begin
               wr_data = hold_ff;
               if (phase_ff == PH_BUILD && k_ff == COUNT_BITS'(1)) begin
                  phase_in = PH_SORT;
                  k_in     = count_ff;
               end else begin
                  k_in = k_less;
               end
            end
         end
         ST_OUT: begin
            rd_a_addr      = out_idx_ff;
            out_idx_in     = out_idx_ff + ADDR_BITS'(1);
            rsp_strobe_in  = 1'b1;
            rsp_last_in    = out_last;
            rsp_dropped_in = overflow_ff;
            if (out_last) begin
               count_in    = '0;
               overflow_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_BUILD;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         k_ff          <= '0;
         out_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         k_ff          <= k_in;
         out_idx_ff    <= out_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      len_ff         <= len_in;
      node_ff        <= node_in;
      hold_ff        <= hold_in;
      left_ok_ff     <= left_ok_in;
      right_ok_ff    <= right_ok_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sorted_value = $signed(rd_a_data);
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_dropped      = rsp_dropped_ff;

   `HS_ASSERT_IMP(a_mid_result_busy, clock, reset, rsp_strobe && !rsp_last_result, busy)
   `HS_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_strobe && rsp_last_result, !rsp_strobe)
   `HS_ASSERT_IMP(a_node_in_heap, clock, reset, state_ff == ST_CMP, COUNT_BITS'(node_ff) < len_ff)
   `HS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_BITS'(MAX_ITEMS))
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for heap_sorter: sends sets of signed values and checks each
// emitted value, last flag and dropped flag against an in-bench sorting predictor.
// Depends on hsort_pkg and the heap_sorter RTL; needs no files or arguments.
module testbench import hsort_pkg::*;;

   localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam int TOTAL_ITEMS   = 310;
   localparam int PHASE_ITEMS   = 103;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 50;

   typedef struct {
      logic signed [VALUE_BITS-1:0] sorted;
      logic                         last;
      logic                         dropped;
   } sorted_result_type;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      logic                         last;
      bit                           echoed;
   } stim_row_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [VALUE_BITS-1:0] req_value;
   logic                         req_last_item;
   logic                         rsp_strobe;
   logic signed [VALUE_BITS-1:0] rsp_sorted_value;
   logic                         rsp_last_result;
   logic                         rsp_dropped;

   sorted_result_type            expected_q[$];
   sorted_result_type            produced_q[$];
   logic signed [VALUE_BITS-1:0] held_values[$];
   logic                         overflow_flag = 1'b0;
   int                           error_count   = 0;
   int                           items_sent    = 0;
   int                           idle_pct      = 0;

   // A single-value set is echoed straight back, marked last and not dropped.
   stim_row_type directed_rows [0:20] = '{
      '{MOST_NEG, 1'b1, 1'b1},
      '{MOST_POS, 1'b1, 1'b1},
      '{32'sd0,   1'b1, 1'b1},
      '{-32'sd1,  1'b1, 1'b1},
      '{32'sd1,   1'b1, 1'b1},
      '{32'sd7,   1'b0, 1'b0},
      '{MOST_POS, 1'b0, 1'b0},
      '{MOST_NEG, 1'b0, 1'b0},
      '{32'sd7,   1'b0, 1'b0},
      '{-32'sd1,  1'b0, 1'b0},
      '{32'sd0,   1'b0, 1'b0},
      '{MOST_NEG, 1'b0, 1'b0},
      '{MOST_POS, 1'b1, 1'b0},
      '{32'sd3,   1'b0, 1'b0},
      '{32'sd2,   1'b0, 1'b0},
      '{32'sd1,   1'b0, 1'b0},
      '{32'sd0,   1'b0, 1'b0},
      '{-32'sd1,  1'b0, 1'b0},
      '{-32'sd2,  1'b1, 1'b0},
      '{-32'sd5,  1'b0, 1'b0},
      '{-32'sd5,  1'b1, 1'b0}
   };

   heap_sorter u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_dropped      (rsp_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   // Stores one value of the current set; on the last one sorts the set in ascending
   // order and leaves its results in produced_q.
   function automatic void sort_set_predict(input logic signed [VALUE_BITS-1:0] v,
                                            input logic fin);
      logic signed [VALUE_BITS-1:0] pick;
      int j;
      produced_q.delete();
      if (held_values.size() < MAX_ITEMS) begin
         held_values.push_back(v);
      end else begin
         overflow_flag = 1'b1;
      end
      if (!fin) return;
      for (int i = 1; i < held_values.size(); i++) begin
         pick = held_values[i];
         j = i;
         while (j > 0 && held_values[j-1] > pick) begin
            held_values[j] = held_values[j-1];
            j--;
         end
         held_values[j] = pick;
      end
      foreach (held_values[i]) begin
         produced_q.push_back('{held_values[i], i == held_values.size() - 1, overflow_flag});
      end
      held_values.delete();
      overflow_flag = 1'b0;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] random_value();
      case ($urandom_range(3))
         0: return $urandom_range(8) - 4;
         1: begin
            case ($urandom_range(3))
               0: return MOST_NEG;
               1: return MOST_POS;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(input logic signed [VALUE_BITS-1:0] v, input logic fin,
                            input bit echoed);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start         <= 1'b1;
      req_value     <= v;
      req_last_item <= fin;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      sort_set_predict(v, fin);
      if (echoed) begin
         expected_q.push_back('{v, 1'b1, 1'b0});
      end else begin
         foreach (produced_q[i]) expected_q.push_back(produced_q[i]);
      end
   endtask

   task automatic wait_for_results(input int limit);
      int waited;
      waited = 0;
      start <= 1'b0;
      while (expected_q.size() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic void set_idle_rate();
      if (items_sent < PHASE_ITEMS) idle_pct = 25;
      else if (items_sent < 2 * PHASE_ITEMS) idle_pct = 71;
      else idle_pct = 0;
   endfunction

   always @(posedge clock) begin
      sorted_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_sorted_value));
         end else begin
            want = expected_q.pop_front();
            if (rsp_sorted_value !== want.sorted)
               report_mismatch($sformatf("sorted value: expected %0d, got %0d",
                                         want.sorted, rsp_sorted_value));
            if (rsp_last_result !== want.last)
               report_mismatch($sformatf("last flag: expected %b, got %b",
                                         want.last, rsp_last_result));
            if (rsp_dropped !== want.dropped)
               report_mismatch($sformatf("dropped flag: expected %b, got %b",
                                         want.dropped, rsp_dropped));
         end
      end
   end

   initial begin
      int  set_len;
      int  sets_done;
      bit  quiet_pause_done;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_value     <= '0;
      req_last_item <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         set_idle_rate();
         send_item(directed_rows[i].value, directed_rows[i].last, directed_rows[i].echoed);
      end
      wait_for_results(DRAIN_LIMIT);

      // The first set fills the store exactly; the second overflows it with its last item.
      sets_done        = 0;
      quiet_pause_done = 1'b0;
      set_len          = MAX_ITEMS;
      while (items_sent < TOTAL_ITEMS) begin
         for (int k = 0; k < set_len; k++) begin
            set_idle_rate();
            send_item(random_value(), k == set_len - 1, 1'b0);
         end
         sets_done++;
         if (!quiet_pause_done && items_sent >= 2 * PHASE_ITEMS) begin
            wait_for_results(DRAIN_LIMIT);
            quiet_pause_done = 1'b1;
         end
         if (sets_done == 1) set_len = MAX_ITEMS + 1;
         else if ($urandom_range(99) < 6) set_len = $urandom_range(MAX_ITEMS + 4, MAX_ITEMS - 2);
         else set_len = $urandom_range(12, 1);
      end

      wait_for_results(DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
      foreach (expected_q[i])
         report_mismatch($sformatf("missing result %0d", expected_q[i].sorted));
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hsort_pkg.sv
rtl/hsort_ram.sv
rtl/heap_sorter.sv
bench/testbench.sv
